// File: rtl/odgs_pkg.sv
`timescale 1ns / 1ps

package odgs_pkg;

  localparam int OUT_LEGS = 4;
  localparam int LEG_W    = 2;
  localparam int OFF_W    = 4;
  localparam int DUR_W    = 5;
  localparam int H_W      = 5;
  localparam int IPS_W    = 8;
  localparam int OFFS_W   = 16;
  localparam int DURS_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFGI_W   = 2;
  localparam int PER_W    = 13;
  localparam int DIV_W    = 32;
  localparam int CNT_W    = 5;
  localparam int FRAC_W   = 16;
  localparam int CON_W    = 17;
  localparam int ROW_W    = 4;

  localparam logic [H_W-1:0]    HORIZON_RST   = H_W'(10);
  localparam logic [IPS_W-1:0]  IPS_RST       = IPS_W'(30);
  localparam logic [OFFS_W-1:0] OFFSETS_RST   = OFFS_W'(1360);
  localparam logic [DURS_W-1:0] DURATIONS_RST = DURS_W'(169125);
  localparam logic [DIV_W-1:0]  ONE_Q16       = DIV_W'(1) << FRAC_W;

  typedef enum logic [CFGI_W-1:0] {
    CFG_HORIZON,
    CFG_IPS,
    CFG_OFFSETS,
    CFG_DURATIONS
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MOD,
    ST_STEP,
    ST_LEG,
    ST_CSET,
    ST_CON,
    ST_SSET,
    ST_SW,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [PER_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [PER_W-1:0] rem;
  } div_rsp_t;

  // offset below 16 reduced modulo a horizon of at least 1
  function automatic logic [OFF_W-1:0] mod_small(input logic [OFF_W-1:0] o,
                                                 input logic [H_W-1:0] h);
    logic [H_W+OFF_W-1:0] a;
    logic [H_W+OFF_W-1:0] b;
    a = (H_W+OFF_W)'(o);
    for (int k = OFF_W - 1; k >= 0; k--) begin
      b = (H_W+OFF_W)'(h) << k;
      if (a >= b) begin
        a = a - b;
      end
    end
    return a[OFF_W-1:0];
  endfunction

endpackage

// File: rtl/offset_duration_gait_scheduler.sv
// offset/duration gait scheduler
// input channel: iteration with in_valid / in_stall, a transfer at a clock edge
// with in_valid high and in_stall low. in_stall stays high from a transfer
// until the last row of that item has been loaded into the output register.
// output channel: one transfer per row (row 0 .. h-1, h being horizon clamped
// to 1 .. MAX_HORIZON, at most 31) with out_valid / out_stall; last marks the
// final row. the output register holds while out_valid and out_stall are high,
// and a new item is taken as soon as the last row sits in it, even if stalled.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// horizon, iters_per_step, leg_offsets or leg_durations; write only when idle.
// sequencing: one shared divider does the period modulo, the step index and
// up to eight progress fractions in turn, plus the ST_LEG, ST_CSET and ST_SSET
// setup states per leg; a leg out of stance or swing skips that division.
// after that, one row per cycle leaves while out_stall is low.
// reset: synchronous, clears the sequencer and output valid and restores the
// register defaults (horizon 10, 30 iterations per step).
`timescale 1ns / 1ps

module offset_duration_gait_scheduler #(
  parameter int MAX_HORIZON = 16,
  parameter int LEGS        = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [odgs_pkg::DIV_W-1:0]    iteration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [odgs_pkg::ROW_W-1:0]    gait_step,
  output logic [odgs_pkg::ROW_W-1:0]    row,
  output logic [odgs_pkg::OUT_LEGS-1:0] stance_mask,
  output logic [odgs_pkg::CON_W-1:0]    contact_leg0,
  output logic [odgs_pkg::CON_W-1:0]    contact_leg1,
  output logic [odgs_pkg::CON_W-1:0]    contact_leg2,
  output logic [odgs_pkg::CON_W-1:0]    contact_leg3,
  output logic [odgs_pkg::FRAC_W-1:0]   swing_leg0,
  output logic [odgs_pkg::FRAC_W-1:0]   swing_leg1,
  output logic [odgs_pkg::FRAC_W-1:0]   swing_leg2,
  output logic [odgs_pkg::FRAC_W-1:0]   swing_leg3,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [odgs_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [odgs_pkg::CFG_W-1:0]    cfg_data
);
  import odgs_pkg::*;

  localparam int HCAP = (MAX_HORIZON > 31) ? 31 : MAX_HORIZON;
  localparam logic [H_W-1:0] HMAX = H_W'(HCAP);
  localparam int NLEG = (LEGS < OUT_LEGS) ? LEGS : OUT_LEGS;
  localparam logic [LEG_W-1:0] LAST_LEG = LEG_W'(NLEG - 1);

  state_t state;
  state_t state_next;

  logic [H_W-1:0]    horizon;
  logic [IPS_W-1:0]  iters_per_step;
  logic [OFFS_W-1:0] leg_offsets;
  logic [DURS_W-1:0] leg_durations;

  logic [DIV_W-1:0]  it_q;
  logic [H_W-1:0]    h_q;
  logic [IPS_W-1:0]  ips_q;
  logic [PER_W-1:0]  period_q;
  logic [PER_W-1:0]  r_q;
  logic [H_W-1:0]    step_q;
  logic [H_W-1:0]    at_q;
  logic [H_W-1:0]    row_i;
  logic [LEG_W-1:0]  leg_q;
  logic [OFF_W-1:0]  off_q     [OUT_LEGS];
  logic [DUR_W-1:0]  dur_q     [OUT_LEGS];
  logic [CON_W-1:0]  contact_q [OUT_LEGS];
  logic [FRAC_W-1:0] swing_q   [OUT_LEGS];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [H_W-1:0]      h_sat;
  logic [IPS_W-1:0]    ips_sat;
  logic [OFF_W-1:0]    cur_o;
  logic [DUR_W-1:0]    cur_d;
  logic [DUR_W-1:0]    new_d;
  logic [PER_W-1:0]    oprod;
  logic [PER_W-1:0]    c_den;
  logic [PER_W:0]      s_sum;
  logic [PER_W-1:0]    s_val;
  logic                c_go;
  logic [H_W:0]        w_sum;
  logic [H_W-1:0]      w_val;
  logic [H_W-1:0]      sd;
  logic [PER_W-1:0]    wprod;
  logic [PER_W-1:0]    s_den;
  logic [PER_W:0]      t_sum;
  logic [PER_W-1:0]    t_val;
  logic                s_go;
  logic                leg_last;
  logic                row_last;
  logic                load;
  logic [H_W-1:0]      step1;
  logic [H_W-1:0]      at_init;
  logic [OUT_LEGS-1:0] mask;
  logic [H_W:0]        p;
  logic [H_W:0]        pr;

  odgs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (horizon == '0) begin
      h_sat = H_W'(1);
    end else if (horizon > HMAX) begin
      h_sat = HMAX;
    end else begin
      h_sat = horizon;
    end
    ips_sat = (iters_per_step == '0) ? IPS_W'(1) : iters_per_step;
  end

  // per-leg datapath
  always_comb begin
    new_d = leg_durations[int'(leg_q) * DUR_W +: DUR_W];
    if (new_d > h_q) begin
      new_d = h_q;
    end
    cur_o = off_q[leg_q];
    cur_d = dur_q[leg_q];
    oprod = PER_W'(cur_o) * PER_W'(ips_q);
    c_den = PER_W'(cur_d) * PER_W'(ips_q);
    s_sum = {1'b0, r_q} + {1'b0, period_q} - {1'b0, oprod};
    s_val = (s_sum >= {1'b0, period_q}) ? PER_W'(s_sum - {1'b0, period_q})
                                        : s_sum[PER_W-1:0];
    c_go  = (cur_d != '0) && (s_val <= c_den);
    w_sum = (H_W+1)'(cur_o) + (H_W+1)'(cur_d);
    w_val = (w_sum >= {1'b0, h_q}) ? H_W'(w_sum - {1'b0, h_q}) : w_sum[H_W-1:0];
    sd    = h_q - cur_d;
    wprod = PER_W'(w_val) * PER_W'(ips_q);
    s_den = PER_W'(sd) * PER_W'(ips_q);
    t_sum = {1'b0, r_q} + {1'b0, period_q} - {1'b0, wprod};
    t_val = (t_sum >= {1'b0, period_q}) ? PER_W'(t_sum - {1'b0, period_q})
                                        : t_sum[PER_W-1:0];
    s_go  = (sd != '0) && (t_val < s_den);
    leg_last = leg_q == LAST_LEG;
    step1    = div_rsp.quo[H_W-1:0] + 1'b1;
    at_init  = (step1 == h_q) ? '0 : step1;
  end

  // stance mask of the row being loaded
  always_comb begin
    mask = '0;
    p    = '0;
    pr   = '0;
    for (int l = 0; l < OUT_LEGS; l++) begin
      p  = (H_W+1)'(at_q) + (H_W+1)'(h_q) - (H_W+1)'(off_q[l]);
      pr = (p >= {1'b0, h_q}) ? p - {1'b0, h_q} : p;
      mask[l] = pr < (H_W+1)'(dur_q[l]);
    end
    row_last = row_i == (h_q - 1'b1);
    load     = !out_valid || !out_stall;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        state_next = ST_MOD;
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (div_rsp.done) begin
          state_next = ST_LEG;
        end
      end
      ST_LEG: begin
        state_next = ST_CSET;
      end
      ST_CSET: begin
        state_next = c_go ? ST_CON : ST_SSET;
      end
      ST_CON: begin
        if (div_rsp.done) begin
          state_next = ST_SSET;
        end
      end
      ST_SSET: begin
        if (s_go) begin
          state_next = ST_SW;
        end else begin
          state_next = leg_last ? ST_ROWS : ST_LEG;
        end
      end
      ST_SW: begin
        if (div_rsp.done) begin
          state_next = leg_last ? ST_ROWS : ST_LEG;
        end
      end
      ST_ROWS: begin
        if (load && row_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall      = state != ST_IDLE;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = PER_W'(1);
    case (state)
      ST_INIT: begin
        div_req.start = 1'b1;
        div_req.num   = it_q;
        div_req.den   = period_q;
      end
      ST_MOD: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_W'(div_rsp.rem);
        div_req.den   = PER_W'(ips_q);
      end
      ST_CSET: begin
        div_req.start = c_go;
        div_req.num   = DIV_W'(s_val) << FRAC_W;
        div_req.den   = c_den;
      end
      ST_SSET: begin
        div_req.start = s_go;
        div_req.num   = DIV_W'(t_val) << FRAC_W;
        div_req.den   = s_den;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      horizon        <= HORIZON_RST;
      iters_per_step <= IPS_RST;
      leg_offsets    <= OFFSETS_RST;
      leg_durations  <= DURATIONS_RST;
    end else begin
      state <= state_next;
      if (state == ST_ROWS && load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HORIZON:   horizon        <= cfg_data[H_W-1:0];
          CFG_IPS:       iters_per_step <= cfg_data[IPS_W-1:0];
          CFG_OFFSETS:   leg_offsets    <= cfg_data[OFFS_W-1:0];
          CFG_DURATIONS: leg_durations  <= cfg_data[DURS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          it_q     <= iteration;
          h_q      <= h_sat;
          ips_q    <= ips_sat;
          period_q <= PER_W'(ips_sat) * PER_W'(h_sat);
          leg_q    <= '0;
          for (int l = 0; l < OUT_LEGS; l++) begin
            off_q[l]     <= '0;
            dur_q[l]     <= '0;
            contact_q[l] <= '0;
            swing_q[l]   <= '0;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          r_q <= div_rsp.rem;
        end
      end
      ST_STEP: begin
        if (div_rsp.done) begin
          step_q <= div_rsp.quo[H_W-1:0];
          at_q   <= at_init;
          row_i  <= '0;
        end
      end
      ST_LEG: begin
        off_q[leg_q] <= mod_small(leg_offsets[int'(leg_q) * OFF_W +: OFF_W], h_q);
        dur_q[leg_q] <= new_d;
      end
      ST_CON: begin
        if (div_rsp.done) begin
          contact_q[leg_q] <= div_rsp.quo[CON_W-1:0];
        end
      end
      ST_SSET: begin
        if (!s_go && !leg_last) begin
          leg_q <= leg_q + 1'b1;
        end
      end
      ST_SW: begin
        if (div_rsp.done) begin
          swing_q[leg_q] <= div_rsp.quo[FRAC_W-1:0];
          if (!leg_last) begin
            leg_q <= leg_q + 1'b1;
          end
        end
      end
      ST_ROWS: begin
        if (load) begin
          gait_step    <= step_q[ROW_W-1:0];
          row          <= row_i[ROW_W-1:0];
          stance_mask  <= mask;
          last         <= row_last;
          contact_leg0 <= contact_q[0];
          contact_leg1 <= contact_q[1];
          contact_leg2 <= contact_q[2];
          contact_leg3 <= contact_q[3];
          swing_leg0   <= swing_q[0];
          swing_leg1   <= swing_q[1];
          swing_leg2   <= swing_q[2];
          swing_leg3   <= swing_q[3];
          row_i        <= row_i + 1'b1;
          at_q         <= (at_q == h_q - 1'b1) ? '0 : at_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_MOD || state == ST_STEP ||
                      state == ST_CON || state == ST_SW))
    else $error("divider finished while the sequencer was not waiting");

  a_contact_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CON && div_rsp.done) |-> div_rsp.quo <= ONE_Q16)
    else $error("stance progress above one");

  a_swing_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SW && div_rsp.done) |-> div_rsp.quo < ONE_Q16)
    else $error("swing progress not below one");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && div_rsp.done) |-> div_rsp.quo < DIV_W'(h_q))
    else $error("gait step outside the horizon");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWS) |-> (row_i < h_q && at_q < h_q))
    else $error("row counter outside the horizon");
`endif

endmodule

// File: rtl/odgs_div.sv
`timescale 1ns / 1ps

module odgs_div (
  input  logic               clk,
  input  logic               rst,
  input  odgs_pkg::div_req_t req,
  output odgs_pkg::div_rsp_t rsp
);
  import odgs_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] num;
  logic [PER_W-1:0] den;
  logic [PER_W-1:0] rem;
  logic [PER_W:0]   trial;
  logic             ge;
  logic [PER_W-1:0] rem_next;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem, num[DIV_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? PER_W'(trial - {1'b0, den}) : trial[PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == '1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      num <= {num[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = num;
  assign rsp.rem  = rem;

endmodule

// File: tb/offset_duration_gait_scheduler_tb.sv
`timescale 1ns / 1ps

module offset_duration_gait_scheduler_tb;
  import odgs_pkg::*;

  localparam int HORIZON_MAX = 16;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ROW_W-1:0]                gait_step;
    logic [ROW_W-1:0]                row;
    logic [OUT_LEGS-1:0]             stance_mask;
    logic [OUT_LEGS-1:0][CON_W-1:0]  contact;
    logic [OUT_LEGS-1:0][FRAC_W-1:0] swing;
    logic                            last;
  } gait_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DIV_W-1:0]    iteration = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ROW_W-1:0]    gait_step;
  logic [ROW_W-1:0]    row;
  logic [OUT_LEGS-1:0] stance_mask;
  logic [CON_W-1:0]    contact_leg0, contact_leg1, contact_leg2, contact_leg3;
  logic [FRAC_W-1:0]   swing_leg0, swing_leg1, swing_leg2, swing_leg3;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFGI_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  logic [H_W-1:0]    cfg_horizon   = HORIZON_RST;
  logic [IPS_W-1:0]  cfg_ips       = IPS_RST;
  logic [OFFS_W-1:0] cfg_offsets   = OFFSETS_RST;
  logic [DURS_W-1:0] cfg_durations = DURATIONS_RST;

  gait_row_t pending_rows[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  offset_duration_gait_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .iteration    (iteration),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .gait_step    (gait_step),
    .row          (row),
    .stance_mask  (stance_mask),
    .contact_leg0 (contact_leg0),
    .contact_leg1 (contact_leg1),
    .contact_leg2 (contact_leg2),
    .contact_leg3 (contact_leg3),
    .swing_leg0   (swing_leg0),
    .swing_leg1   (swing_leg1),
    .swing_leg2   (swing_leg2),
    .swing_leg3   (swing_leg3),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  task automatic report(input string msg);
    if (mismatches < 10) begin
      $display("%s", msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      report($sformatf("%s: expected %0d, got %0d", name, want, got));
    end
  endtask

  // rows of one iteration: phase in the gait cycle, leg progress, stance masks
  task automatic predict_rows(input logic [DIV_W-1:0] it);
    int unsigned h, ips, period, r, step, o, d, s, w, sd, t, at;
    int unsigned offs [OUT_LEGS];
    int unsigned durs [OUT_LEGS];
    gait_row_t   rw;
    h = cfg_horizon;
    if (h < 1) h = 1;
    if (h > HORIZON_MAX) h = HORIZON_MAX;
    ips = cfg_ips;
    if (ips < 1) ips = 1;
    period = ips * h;
    r = it % period;
    step = (it / ips) % h;
    rw = '0;
    rw.gait_step = ROW_W'(step);
    for (int leg = 0; leg < OUT_LEGS; leg++) begin
      o = ((cfg_offsets >> (OFF_W * leg)) & 'hF) % h;
      d = (cfg_durations >> (DUR_W * leg)) & 'h1F;
      if (d > h) d = h;
      offs[leg] = o;
      durs[leg] = d;
      s = (r + period - o * ips) % period;
      w = o + d;
      if (w >= h) w -= h;
      sd = h - d;
      t = (r + period - w * ips) % period;
      if (d > 0 && s <= d * ips) rw.contact[leg] = CON_W'((s << FRAC_W) / (d * ips));
      if (sd > 0 && t < sd * ips) rw.swing[leg] = FRAC_W'((t << FRAC_W) / (sd * ips));
    end
    for (int i = 0; i < h; i++) begin
      at = (i + step + 1) % h;
      rw.row = ROW_W'(i);
      rw.stance_mask = '0;
      for (int leg = 0; leg < OUT_LEGS; leg++) begin
        if ((at + h - offs[leg]) % h < durs[leg]) rw.stance_mask[leg] = 1'b1;
      end
      rw.last = (i == h - 1);
      pending_rows.push_back(rw);
    end
  endtask

  always @(posedge clk) begin : row_check
    gait_row_t got;
    gait_row_t want;
    got.gait_step = gait_step;
    got.row = row;
    got.stance_mask = stance_mask;
    got.contact = {contact_leg3, contact_leg2, contact_leg1, contact_leg0};
    got.swing = {swing_leg3, swing_leg2, swing_leg1, swing_leg0};
    got.last = last;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        report($sformatf("unexpected row %0d, step %0d", row, gait_step));
      end else begin
        want = pending_rows.pop_front();
        check_field("gait_step", want.gait_step, got.gait_step);
        check_field("row", want.row, got.row);
        check_field("stance_mask", want.stance_mask, got.stance_mask);
        for (int leg = 0; leg < OUT_LEGS; leg++) begin
          check_field($sformatf("contact_leg%0d", leg), want.contact[leg], got.contact[leg]);
          check_field($sformatf("swing_leg%0d", leg), want.swing[leg], got.swing[leg]);
        end
        check_field("last", want.last, got.last);
      end
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 49;
        stall_pct = 0;
      end
      IDLE_STALL: begin
        send_idle_pct = 0;
        stall_pct = 49;
      end
      default: begin
        send_idle_pct = 15;
        stall_pct = 15;
      end
    endcase
  endtask

  task automatic send_iteration(input logic [DIV_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    iteration = value;
    do @(posedge clk); while (in_stall);
    predict_rows(value);
  endtask

  task automatic wait_rows_done();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rows.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HORIZON:   cfg_horizon = value[H_W-1:0];
      CFG_IPS:       cfg_ips = value[IPS_W-1:0];
      CFG_OFFSETS:   cfg_offsets = value[OFFS_W-1:0];
      CFG_DURATIONS: cfg_durations = value[DURS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_gait(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] ips,
                            input logic [CFG_W-1:0] offs, input logic [CFG_W-1:0] durs);
    wait_rows_done();
    write_reg(CFG_HORIZON, h);
    write_reg(CFG_IPS, ips);
    write_reg(CFG_OFFSETS, offs);
    write_reg(CFG_DURATIONS, durs);
  endtask

  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    send_iteration(0);
    send_iteration(1);
    send_iteration(29);
    send_iteration(30);
    send_iteration(299);
    send_iteration(300);
    send_iteration(32'hFFFF_FFFF);
  endtask

  // zero, full and oversized durations, offset past the horizon
  task automatic test_stance_edges();
    set_idling(IDLE_BOTH);
    write_gait(8, 4, 16'hF730, 20'h1FD00);
    send_iteration(0);
    send_iteration(13);
    send_iteration(31);
    send_iteration(32'h8000_0000);
    send_iteration(32'hFFFF_FFFF);
  endtask

  task automatic test_range_extremes();
    set_idling(IDLE_STALL);
    write_gait(0, 0, 16'hFFFF, 20'hFFFFF);
    send_iteration(0);
    send_iteration(32'hFFFF_FFFF);
    write_gait(31, 255, 16'h0000, 20'h00000);
    send_iteration(4079);
    send_iteration(4080);
    send_iteration(32'hFFFF_FFFF);
    write_gait(16, 1, 16'hFEDC, 20'h5A5A5);
    send_iteration(5);
    send_iteration(32'h7FFF_FFFF);
    write_gait(17, 128, 16'h3210, 20'h18C63);
    send_iteration(1);
  endtask

  task automatic test_random_gaits();
    int unsigned h, eff_h, half, ips;
    logic [OFFS_W-1:0] offs;
    logic [DURS_W-1:0] durs;
    logic [DIV_W-1:0]  counter;
    logic [DIV_W-1:0]  value;
    for (int phase = 0; phase < 8; phase++) begin
      h = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
      eff_h = (h < 1) ? 1 : (h > HORIZON_MAX) ? HORIZON_MAX : h;
      half = eff_h / 2;
      ips = $urandom_range(255);
      if ($urandom_range(1) == 0) begin
        offs = {4'(0), 4'(half), 4'(half), 4'(0)};
        durs = {4{5'(half)}};
      end else begin
        offs = OFFS_W'($urandom);
        durs = DURS_W'($urandom);
      end
      write_gait({15'($urandom), 5'(h)}, {12'($urandom), 8'(ips)},
                 {4'($urandom), offs}, durs);
      set_idling(idle_mode_t'(phase % 4));
      counter = $urandom;
      for (int n = 0; n < 25; n++) begin
        case ($urandom_range(2))
          0: value = $urandom;
          1: value = $urandom_range(8191);
          default: begin
            counter += $urandom_range(1, 64);
            value = counter;
          end
        endcase
        send_iteration(value);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_stance_edges();
    test_range_extremes();
    test_random_gaits();
    wait_rows_done();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("offset_duration_gait_scheduler_tb: clean");
    end else begin
      $display("offset_duration_gait_scheduler_tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("offset_duration_gait_scheduler_tb: errors");
    $finish;
  end

endmodule
